[sv/trs_pkg.sv]
// Package for the tagged ring store: sizes, command codes, entry and result types.
// No dependencies; every other file of the block uses it by scoped names.
package trs_pkg;

    // Table geometry and stored field widths
    localparam int DEPTH       = 16;
    localparam int TAG_BITS    = 16;
    localparam int HANDLE_BITS = 32;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    // Scan address, one bit above the index so it can run past the last entry
    localparam int SCAN_W      = IDX_W + 1;

    // Port field widths
    localparam int CMD_W    = 2;
    localparam int TAG_IN_W = 16;
    localparam int HDL_IN_W = 32;
    localparam int TIME_W   = 32;
    localparam int SMALL_W  = 5;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_STORE    = 2'd0,
        CMD_RETRIEVE = 2'd1,
        CMD_CLEANUP  = 2'd2,
        CMD_TICK     = 2'd3
    } t_cmd;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // One table entry (valid bit lives in flops outside the memory)
    typedef struct packed {
        logic [TAG_BITS-1:0]    tag;
        logic [HANDLE_BITS-1:0] handle_a;
        logic [HANDLE_BITS-1:0] handle_b;
        logic [TIME_W-1:0]      stamp;
    } t_entry;

    // Memory write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

    // One response
    typedef struct packed {
        logic                status;
        logic [HDL_IN_W-1:0] first_out;
        logic [HDL_IN_W-1:0] second_out;
        logic                overwrote;
        logic [SMALL_W-1:0]  cleaned;
        logic [SMALL_W-1:0]  occupancy;
    } t_result;

endpackage

[sv/trs_if.sv]
// Request and response channel interfaces of the tagged ring store.
// Depends on trs_pkg for field widths.
interface trs_in_if;
    logic                           valid;
    logic                           ready;
    logic [trs_pkg::CMD_W-1:0]      cmd;
    logic [trs_pkg::TAG_IN_W-1:0]   tag_in;
    logic [trs_pkg::HDL_IN_W-1:0]   first_handle;
    logic [trs_pkg::HDL_IN_W-1:0]   second_handle;

    modport source (output valid, cmd, tag_in, first_handle, second_handle, input ready);
    modport sink   (input valid, cmd, tag_in, first_handle, second_handle, output ready);
endinterface

interface trs_out_if;
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic [trs_pkg::HDL_IN_W-1:0]   first_out;
    logic [trs_pkg::HDL_IN_W-1:0]   second_out;
    logic                           overwrote;
    logic [trs_pkg::SMALL_W-1:0]    cleaned;
    logic [trs_pkg::SMALL_W-1:0]    occupancy;

    modport source (output valid, status, first_out, second_out, overwrote, cleaned,
                    occupancy, input ready);
    modport sink   (input valid, status, first_out, second_out, overwrote, cleaned,
                    occupancy, output ready);
endinterface

[sv/trs_entry_mem.sv]
// Entry memory of the tagged ring store: one write port, one registered read port.
// Depends on trs_pkg for the entry type and depth.
module trs_entry_mem (
    input  logic                         i_clk,
    input  trs_pkg::t_mem_wr             i_wr,
    input  logic [trs_pkg::IDX_W-1:0]    i_rd_addr,
    output trs_pkg::t_entry              o_rd_data
);

    trs_pkg::t_entry r_mem [trs_pkg::DEPTH];
    trs_pkg::t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/trs_match_unit.sv]
// Shared compare unit: tag equality for retrieve, age-over-limit for cleanup.
// Depends on trs_pkg for command codes and widths.
module trs_match_unit (
    input  trs_pkg::t_cmd                   i_op,
    input  trs_pkg::t_entry                 i_entry,
    input  logic [trs_pkg::TAG_BITS-1:0]    i_key,
    input  logic [trs_pkg::TIME_W-1:0]      i_now,
    input  logic [trs_pkg::TIME_W-1:0]      i_max_age,
    output logic                            o_hit
);

    logic [trs_pkg::TIME_W-1:0] age;

    // Age wraps with the time counter
    assign age = i_now - i_entry.stamp;

    always_comb begin
        case (i_op)
            trs_pkg::CMD_RETRIEVE: o_hit = (i_entry.tag == i_key);
            trs_pkg::CMD_CLEANUP:  o_hit = (age > i_max_age);
            default:               o_hit = 1'b0;
        endcase
    end

endmodule

[sv/tagged_ring_store_with_expiry.sv]
// Top level of the tagged ring store with expiry: sequencer, valid flags, counters.
// Depends on trs_pkg, trs_if, trs_entry_mem and trs_match_unit.
//
//   channel   dir  handshake     payload
//   i_req     in   valid/ready   cmd, tag_in, first_handle, second_handle
//   o_rsp     out  valid/ready   status, first_out, second_out, overwrote, cleaned, occupancy
//   i_cfg     in   i_cfg_we      i_cfg_data (max_age)
//
// Store and tick pass through the done state, which loads the response register.
// Retrieve and cleanup walk the table one entry a cycle through the single compare
// unit behind the registered memory read; retrieve stops at the first hit. Input ready
// is high only in the idle state. Synchronous active-low reset clears all valid flags,
// the entry count, the time counter and the write pointer, and sets max_age to all ones.
// A full response register holds the sequencer in its done state until it is taken.
module tagged_ring_store_with_expiry (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    trs_in_if.sink                       i_req,
    trs_out_if.source                    o_rsp,
    input  logic                         i_cfg_we,
    input  logic [trs_pkg::TIME_W-1:0]   i_cfg_data
);

    trs_pkg::t_state                    r_state, n_state;
    logic [trs_pkg::TIME_W-1:0]         r_max_age, n_max_age;
    logic [trs_pkg::TIME_W-1:0]         r_now, n_now;
    logic [trs_pkg::IDX_W-1:0]          r_wp, n_wp;
    logic [trs_pkg::CNT_W-1:0]          r_count, n_count;
    logic [trs_pkg::CNT_W-1:0]          r_cleaned, n_cleaned;
    logic [trs_pkg::DEPTH-1:0]          r_valid, n_valid;
    trs_pkg::t_cmd                      r_op, n_op;
    logic [trs_pkg::TAG_BITS-1:0]       r_key, n_key;
    logic [trs_pkg::SCAN_W-1:0]         r_addr, n_addr;
    logic                               r_eval, n_eval;
    logic [trs_pkg::IDX_W-1:0]          r_eval_idx, n_eval_idx;
    trs_pkg::t_result                   r_res, n_res;
    trs_pkg::t_result                   r_out, n_out;
    logic                               r_out_vld, n_out_vld;

    trs_pkg::t_mem_wr                   mem_wr;
    logic [trs_pkg::IDX_W-1:0]          rd_addr;
    trs_pkg::t_entry                    rd_data;
    logic                               unit_hit;
    logic                               hit;
    logic                               issue;
    logic                               accept;

    trs_entry_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    trs_match_unit u_match (
        .i_op      (r_op),
        .i_entry   (rd_data),
        .i_key     (r_key),
        .i_now     (r_now),
        .i_max_age (r_max_age),
        .o_hit     (unit_hit)
    );

    // Handshakes
    assign i_req.ready = (r_state == trs_pkg::ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    // Scan address issue
    assign issue   = (r_state == trs_pkg::ST_SCAN)
                     && (r_addr < trs_pkg::SCAN_W'(trs_pkg::DEPTH));
    assign rd_addr = issue ? r_addr[trs_pkg::IDX_W-1:0] : '0;
    assign hit     = r_eval && r_valid[r_eval_idx] && unit_hit;

    // Next-state logic
    always_comb begin
        n_state    = r_state;
        n_max_age  = r_max_age;
        n_now      = r_now;
        n_wp       = r_wp;
        n_count    = r_count;
        n_cleaned  = r_cleaned;
        n_valid    = r_valid;
        n_op       = r_op;
        n_key      = r_key;
        n_addr     = r_addr;
        n_eval     = r_eval;
        n_eval_idx = r_eval_idx;
        n_res      = r_res;
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        mem_wr     = '0;

        // config write
        if (i_cfg_we) begin
            n_max_age = i_cfg_data;
        end

        // response taken
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            trs_pkg::ST_IDLE: begin
                if (accept) begin
                    n_op      = trs_pkg::t_cmd'(i_req.cmd);
                    n_key     = trs_pkg::TAG_BITS'(i_req.tag_in);
                    n_res     = '0;
                    n_cleaned = '0;
                    case (trs_pkg::t_cmd'(i_req.cmd))
                        trs_pkg::CMD_STORE: begin
                            mem_wr.en            = 1'b1;
                            mem_wr.addr          = r_wp;
                            mem_wr.data.tag      = trs_pkg::TAG_BITS'(i_req.tag_in);
                            mem_wr.data.handle_a = trs_pkg::HANDLE_BITS'(i_req.first_handle);
                            mem_wr.data.handle_b = trs_pkg::HANDLE_BITS'(i_req.second_handle);
                            mem_wr.data.stamp    = r_now;
                            n_valid[r_wp]        = 1'b1;
                            if (r_valid[r_wp]) begin
                                n_res.overwrote = 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                            if (r_wp == trs_pkg::IDX_W'(trs_pkg::DEPTH - 1)) begin
                                n_wp = '0;
                            end else begin
                                n_wp = r_wp + 1'b1;
                            end
                            n_state = trs_pkg::ST_DONE;
                        end
                        trs_pkg::CMD_RETRIEVE, trs_pkg::CMD_CLEANUP: begin
                            n_addr  = '0;
                            n_eval  = 1'b0;
                            n_state = trs_pkg::ST_SCAN;
                        end
                        default: begin
                            n_now   = r_now + 1'b1;
                            n_state = trs_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            trs_pkg::ST_SCAN: begin
                // issue the next read
                if (issue) begin
                    n_eval     = 1'b1;
                    n_eval_idx = r_addr[trs_pkg::IDX_W-1:0];
                    n_addr     = r_addr + 1'b1;
                end else begin
                    n_eval = 1'b0;
                end
                // evaluate the entry read last cycle
                if (hit) begin
                    n_valid[r_eval_idx] = 1'b0;
                    n_count             = r_count - 1'b1;
                    if (r_op == trs_pkg::CMD_RETRIEVE) begin
                        n_res.first_out  = trs_pkg::HDL_IN_W'(rd_data.handle_a);
                        n_res.second_out = trs_pkg::HDL_IN_W'(rd_data.handle_b);
                        n_state          = trs_pkg::ST_DONE;
                    end else begin
                        n_cleaned = r_cleaned + 1'b1;
                    end
                end
                // last entry checked without a retrieve hit
                if (r_eval && (r_eval_idx == trs_pkg::IDX_W'(trs_pkg::DEPTH - 1))
                        && !(hit && (r_op == trs_pkg::CMD_RETRIEVE))) begin
                    if (r_op == trs_pkg::CMD_RETRIEVE) begin
                        n_res.status = 1'b1;
                    end
                    n_state = trs_pkg::ST_DONE;
                end
            end

            trs_pkg::ST_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out           = r_res;
                    n_out.cleaned   = trs_pkg::SMALL_W'(r_cleaned);
                    n_out.occupancy = trs_pkg::SMALL_W'(r_count);
                    n_out_vld       = 1'b1;
                    n_state         = trs_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = trs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= trs_pkg::ST_IDLE;
            r_max_age <= '1;
            r_now     <= '0;
            r_wp      <= '0;
            r_count   <= '0;
            r_valid   <= '0;
            r_eval    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_max_age <= n_max_age;
            r_now     <= n_now;
            r_wp      <= n_wp;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_eval    <= n_eval;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cleaned  <= n_cleaned;
        r_op       <= n_op;
        r_key      <= n_key;
        r_addr     <= n_addr;
        r_eval_idx <= n_eval_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // Response port
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.first_out  = r_out.first_out;
    assign o_rsp.second_out = r_out.second_out;
    assign o_rsp.overwrote  = r_out.overwrote;
    assign o_rsp.cleaned    = r_out.cleaned;
    assign o_rsp.occupancy  = r_out.occupancy;

endmodule
